[hw/rtl/drf_pkg.sv]
// Shared types and constants for the decimal readout formatter.
package drf_pkg;

	localparam int THRESH_W = 14;
	localparam int TEMP_W   = 16;
	localparam int COUNT_W  = 20;
	localparam int CHAR_W   = 8;

	localparam logic [THRESH_W-1:0] THRESH_RESET = 14'd378;
	localparam logic [TEMP_W-1:0]   TEMP_MAX     = 16'd9999;
	localparam logic [COUNT_W-1:0]  COUNT_MAX    = 20'd999999;

	// Reciprocal of 1000 scaled by 2**30; exact for every 20-bit dividend.
	localparam logic [40:0] RECIP_1000 = 41'd1073742;
	// Reciprocals of 100 (scaled by 2**12) and 10 (scaled by 2**11), exact below 1024.
	localparam logic [15:0] RECIP_100  = 16'd41;
	localparam logic [17:0] RECIP_10   = 18'd205;

	localparam logic [CHAR_W-1:0] CH_ZERO   = 8'h30;
	localparam logic [CHAR_W-1:0] CH_BLANK  = 8'h20;
	localparam logic [CHAR_W-1:0] CH_DEGREE = 8'h7F;
	localparam logic [CHAR_W-1:0] CH_PLUS   = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_MINUS  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_POINT  = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CH_UNIT_C = 8'h43;
	localparam logic [CHAR_W-1:0] CH_NUL    = 8'h00;

	typedef enum logic {
		CMD_TEMP  = 1'b0,
		CMD_COUNT = 1'b1
	} cmd_t;

	typedef enum logic [1:0] {
		COL_DEFAULT = 2'd0,
		COL_BLUE    = 2'd1,
		COL_GREEN   = 2'd2,
		COL_RED     = 2'd3
	} colour_t;

	// One classified request as it waits between front and back.
	typedef struct packed {
		cmd_t               cmd;
		logic               positive;
		colour_t            colour;
		logic [COUNT_W-1:0] value;
	} entry_t;

endpackage

[hw/rtl/drf_in_if.sv]
// Request channel of the decimal readout formatter.
interface drf_in_if;
	logic               valid;
	logic               ready;
	logic               command;
	logic signed [15:0] temp_tenths;
	logic [19:0]        count_value;

	modport source(output valid, output command, output temp_tenths, output count_value,
		input ready);
	modport sink(input valid, input command, input temp_tenths, input count_value,
		output ready);
endinterface

[hw/rtl/drf_out_if.sv]
// Result channel of the decimal readout formatter.
interface drf_out_if;
	logic       valid;
	logic       ready;
	logic [7:0] char0;
	logic [7:0] char1;
	logic [7:0] char2;
	logic [7:0] char3;
	logic [7:0] char4;
	logic [7:0] char5;
	logic [7:0] char6;
	logic [7:0] char7;
	logic [1:0] colour_class;

	modport source(output valid, output char0, output char1, output char2, output char3,
		output char4, output char5, output char6, output char7, output colour_class,
		input ready);
	modport sink(input valid, input char0, input char1, input char2, input char3,
		input char4, input char5, input char6, input char7, input colour_class,
		output ready);
endinterface

[hw/rtl/drf_front.sv]
// Front end: accepts requests, saturates values and keeps the colour class.
module drf_front import drf_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata,
	drf_in_if.sink              in_ch,
	input  logic                q_full,
	output logic                push,
	output entry_t              push_entry
);

	logic [THRESH_W-1:0] thresh_q;
	colour_t             colour_q;
	logic                neg;
	logic                positive;
	logic [TEMP_W-1:0]   mag;
	logic [TEMP_W-1:0]   shown;
	logic [COUNT_W-1:0]  count_sat;
	colour_t             temp_colour;

	assign in_ch.ready = !q_full;
	assign push        = in_ch.valid && !q_full;

	always_comb begin
		neg       = in_ch.temp_tenths[TEMP_W-1];
		positive  = !neg && (in_ch.temp_tenths != '0);
		// The most negative input negates to 0x8000, which is still the right magnitude.
		mag       = neg ? (~in_ch.temp_tenths + 16'd1) : in_ch.temp_tenths;
		shown     = (mag > TEMP_MAX) ? TEMP_MAX : mag;
		count_sat = (in_ch.count_value > COUNT_MAX) ? COUNT_MAX : in_ch.count_value;
		if (!positive) begin
			temp_colour = COL_BLUE;
		end else if (mag < {2'b00, thresh_q}) begin
			temp_colour = COL_GREEN;
		end else begin
			temp_colour = COL_RED;
		end
		push_entry.cmd      = cmd_t'(in_ch.command);
		push_entry.positive = positive;
		if (in_ch.command == CMD_TEMP) begin
			push_entry.colour = temp_colour;
			push_entry.value  = COUNT_W'(shown);
		end else begin
			push_entry.colour = colour_q;
			push_entry.value  = count_sat;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thresh_q <= THRESH_RESET;
			colour_q <= COL_DEFAULT;
		end else begin
			if (cfg_we) begin
				thresh_q <= cfg_wdata;
			end
			if (push && (in_ch.command == CMD_TEMP)) begin
				colour_q <= temp_colour;
			end
		end
	end

endmodule

[hw/rtl/drf_queue.sv]
// Short queue of classified requests between front and back.
module drf_queue import drf_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   push,
	input  entry_t push_entry,
	output logic   full,
	input  logic   pop,
	output logic   head_valid,
	output entry_t head_entry
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	entry_t             mem_q [DEPTH];
	logic [PTR_W-1:0]   wr_ptr_q;
	logic [PTR_W-1:0]   rd_ptr_q;
	logic [CNT_W-1:0]   count_q;
	logic               do_pop;

	assign full       = (count_q == CNT_W'(DEPTH));
	assign head_valid = (count_q != '0);
	assign head_entry = mem_q[rd_ptr_q];
	assign do_pop     = pop && head_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_entry;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !do_pop) begin
				count_q <= count_q + 1'b1;
			end else if (do_pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

[hw/rtl/drf_back.sv]
// Back end: splits the value into decimal digits and lays out the characters.
module drf_back import drf_pkg::*; (
	input  logic   clk,
	input  logic   arst_n,
	input  logic   head_valid,
	input  entry_t head_entry,
	output logic   pop,
	drf_out_if.source out_ch
);

	logic free_o, free3, free2, free1;

	// Stage 1: value divided by 1000.
	logic               v_s1;
	entry_t             e_s1;
	logic [9:0]         q1000_s1;
	logic [40:0]        prod1000;

	// Stage 2: upper and lower three-digit groups.
	logic               v_s2;
	entry_t             e_s2;
	logic [9:0]         hi_s2;
	logic [9:0]         lo_s2;
	logic [COUNT_W-1:0] lo_full;

	// Stage 3: each group divided by 100 and by 10.
	logic               v_s3;
	entry_t             e_s3;
	logic [9:0]         hi_s3, lo_s3;
	logic [3:0]         hi100_s3, lo100_s3;
	logic [6:0]         hi10_s3, lo10_s3;
	logic [15:0]        hi_p100, lo_p100;
	logic [17:0]        hi_p10, lo_p10;

	// Output register.
	logic               out_valid_q;
	logic [CHAR_W-1:0]  c0_q, c1_q, c2_q, c3_q, c4_q, c5_q, c6_q, c7_q;
	colour_t            colour_out_q;

	logic [3:0]         d5, d4, d3, d2, d1, d0;
	logic [6:0]         hi_t, lo_t;
	logic [9:0]         hi_u, lo_u;
	logic               ge1000, ge100, ge10;
	logic [CHAR_W-1:0]  c0, c1, c2, c3, c4, c5, c6, c7;

	assign free_o = !out_valid_q || out_ch.ready;
	assign free3  = !v_s3 || free_o;
	assign free2  = !v_s2 || free3;
	assign free1  = !v_s1 || free2;
	assign pop    = free1;

	assign prod1000 = {21'd0, head_entry.value} * RECIP_1000;
	assign lo_full  = e_s1.value - COUNT_W'(q1000_s1) * 20'd1000;
	assign hi_p100  = {6'd0, hi_s2} * RECIP_100;
	assign lo_p100  = {6'd0, lo_s2} * RECIP_100;
	assign hi_p10   = {8'd0, hi_s2} * RECIP_10;
	assign lo_p10   = {8'd0, lo_s2} * RECIP_10;

	always_comb begin
		hi_t   = hi10_s3 - 7'(hi100_s3) * 7'd10;
		lo_t   = lo10_s3 - 7'(lo100_s3) * 7'd10;
		hi_u   = hi_s3 - 10'(hi10_s3) * 10'd10;
		lo_u   = lo_s3 - 10'(lo10_s3) * 10'd10;
		d5     = hi100_s3;
		d4     = hi_t[3:0];
		d3     = hi_u[3:0];
		d2     = lo100_s3;
		d1     = lo_t[3:0];
		d0     = lo_u[3:0];
		ge1000 = (hi_s3 != '0);
		ge100  = ge1000 || (d2 != '0);
		ge10   = ge100 || (d1 != '0);
		if (e_s3.cmd == CMD_TEMP) begin
			c0 = e_s3.positive ? CH_PLUS : CH_MINUS;
			c1 = CH_ZERO + {4'd0, d3};
			c2 = CH_ZERO + {4'd0, d2};
			c3 = CH_ZERO + {4'd0, d1};
			c4 = CH_POINT;
			c5 = CH_ZERO + {4'd0, d0};
			c6 = CH_DEGREE;
			c7 = CH_UNIT_C;
		end else begin
			c0 = (d5 != '0) ? CH_ZERO + {4'd0, d5} : CH_BLANK;
			c1 = ((d5 != '0) || (d4 != '0)) ? CH_ZERO + {4'd0, d4} : CH_BLANK;
			c2 = ge1000 ? CH_ZERO + {4'd0, d3} : CH_BLANK;
			c3 = ge1000 ? CH_COMMA : CH_BLANK;
			c4 = ge100 ? CH_ZERO + {4'd0, d2} : CH_BLANK;
			c5 = ge10 ? CH_ZERO + {4'd0, d1} : CH_BLANK;
			c6 = CH_ZERO + {4'd0, d0};
			c7 = CH_NUL;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (free1) begin
				v_s1 <= head_valid;
			end
			if (free2) begin
				v_s2 <= v_s1;
			end
			if (free3) begin
				v_s3 <= v_s2;
			end
			if (free_o) begin
				out_valid_q <= v_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (free1 && head_valid) begin
			e_s1     <= head_entry;
			q1000_s1 <= prod1000[39:30];
		end
		if (free2 && v_s1) begin
			e_s2  <= e_s1;
			hi_s2 <= q1000_s1;
			lo_s2 <= lo_full[9:0];
		end
		if (free3 && v_s2) begin
			e_s3     <= e_s2;
			hi_s3    <= hi_s2;
			lo_s3    <= lo_s2;
			hi100_s3 <= hi_p100[15:12];
			lo100_s3 <= lo_p100[15:12];
			hi10_s3  <= hi_p10[17:11];
			lo10_s3  <= lo_p10[17:11];
		end
		if (free_o && v_s3) begin
			c0_q         <= c0;
			c1_q         <= c1;
			c2_q         <= c2;
			c3_q         <= c3;
			c4_q         <= c4;
			c5_q         <= c5;
			c6_q         <= c6;
			c7_q         <= c7;
			colour_out_q <= e_s3.colour;
		end
	end

	assign out_ch.valid        = out_valid_q;
	assign out_ch.char0        = c0_q;
	assign out_ch.char1        = c1_q;
	assign out_ch.char2        = c2_q;
	assign out_ch.char3        = c3_q;
	assign out_ch.char4        = c4_q;
	assign out_ch.char5        = c5_q;
	assign out_ch.char6        = c6_q;
	assign out_ch.char7        = c7_q;
	assign out_ch.colour_class = colour_out_q;

endmodule

[hw/rtl/decimal_readout_formatter.sv]
// Path: an accepted request passes the queue, the three digit stages and the output register.
// Throughput: one request per cycle while results are taken. When a result waits, the three
// digit stages behind the output register and the queue (two entries by default) take five
// more requests before ready drops; one free stage lets one more request in.
// Reset (arst_n low, asynchronous): queue and pipeline empty, threshold 378 tenths,
// kept colour class back to the default font.
module decimal_readout_formatter import drf_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [THRESH_W-1:0] cfg_wdata,
	drf_in_if.sink              in_ch,
	drf_out_if.source           out_ch
);

	// The front end classifies each request as it arrives: it saturates the
	// temperature magnitude or the count, picks the sign, and updates the kept
	// colour class in request order, so every entry already carries its colour.
	logic   q_full;
	logic   push;
	entry_t push_entry;

	// The back end pulls entries from the queue and turns the saturated value
	// into decimal digits by multiplying with exact reciprocals.
	logic   pop;
	logic   head_valid;
	entry_t head_entry;

	drf_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata),
		.in_ch      (in_ch),
		.q_full     (q_full),
		.push       (push),
		.push_entry (push_entry)
	);

	// The queue lets the front keep accepting requests for a while when the
	// result side stalls, and lets the back drain while no requests arrive.
	drf_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_entry (push_entry),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_entry (head_entry)
	);

	drf_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_entry (head_entry),
		.pop        (pop),
		.out_ch     (out_ch)
	);

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps
// Testbench for the decimal readout formatter: directed and random requests checked against a predictor.
module tb;
	import drf_pkg::*;

	// One expected or observed readout: text[i] holds char i, left to right.
	typedef struct packed {
		logic [7:0][CHAR_W-1:0] text;
		colour_t                colour;
	} readout_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_we;
	logic [THRESH_W-1:0] cfg_wdata;

	drf_in_if  req_ch();
	drf_out_if res_ch();

	decimal_readout_formatter DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.in_ch     (req_ch),
		.out_ch    (res_ch)
	);

	// The predictor keeps its own copy of the threshold register and of the colour class
	// that temperature requests leave behind for later count requests.
	logic [THRESH_W-1:0] warm_thresh;
	colour_t             kept_colour;

	// Readouts predicted for accepted requests, oldest first.
	readout_t pending_readouts[$];
	int       mismatch_count = 0;

	// Pacing controls. In steady mode a side never idles; a nonzero hold-off makes the
	// receiver refuse results for that many cycles so the block backs up into its input.
	bit          sender_steady   = 1'b0;
	bit          receiver_steady = 1'b0;
	int unsigned hold_off_cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// The run is cut off here if the handshakes ever stop making progress.
	initial begin
		#2_000_000;
		$display("TEST FAILED");
		$finish;
	end

	function automatic logic [CHAR_W-1:0] digit_of(int unsigned v);
		return CH_ZERO + CHAR_W'(v % 10);
	endfunction

	// Works out the readout for one accepted request and updates the kept colour class.
	// Temperature magnitudes saturate at 999.9 for display, but the colour decision uses the
	// full magnitude against all 14 threshold bits. Zero counts as cold: a minus sign and blue.
	function automatic readout_t format_readout(cmd_t cmd, logic [TEMP_W-1:0] temp,
			logic [COUNT_W-1:0] count);
		readout_t    r;
		logic        positive;
		int unsigned mag;
		int unsigned shown;
		int unsigned n;
		r = '0;
		if (cmd == CMD_TEMP) begin
			positive = !temp[TEMP_W-1] && (temp != '0);
			// The most negative input has magnitude 32768, one beyond the positive range.
			mag = temp[TEMP_W-1] ? 32'h10000 - 32'(temp) : 32'(temp);
			shown = (mag > 32'(TEMP_MAX)) ? 32'(TEMP_MAX) : mag;
			r.text[0] = positive ? CH_PLUS : CH_MINUS;
			r.text[1] = digit_of(shown / 1000);
			r.text[2] = digit_of(shown / 100);
			r.text[3] = digit_of(shown / 10);
			r.text[4] = CH_POINT;
			r.text[5] = digit_of(shown);
			r.text[6] = CH_DEGREE;
			r.text[7] = CH_UNIT_C;
			if (!positive) begin
				kept_colour = COL_BLUE;
			end else if (mag < 32'(warm_thresh)) begin
				kept_colour = COL_GREEN;
			end else begin
				kept_colour = COL_RED;
			end
		end else begin
			// Counts saturate at 999,999 and leading digits are blanked; the thousands
			// comma goes blank together with the thousands digit.
			n = 32'((count > COUNT_MAX) ? COUNT_MAX : count);
			r.text[0] = (n >= 100000) ? digit_of(n / 100000) : CH_BLANK;
			r.text[1] = (n >= 10000) ? digit_of(n / 10000) : CH_BLANK;
			r.text[2] = (n >= 1000) ? digit_of(n / 1000) : CH_BLANK;
			r.text[3] = (n >= 1000) ? CH_COMMA : CH_BLANK;
			r.text[4] = (n >= 100) ? digit_of(n / 100) : CH_BLANK;
			r.text[5] = (n >= 10) ? digit_of(n / 10) : CH_BLANK;
			r.text[6] = digit_of(n);
			r.text[7] = CH_NUL;
		end
		r.colour = kept_colour;
		return r;
	endfunction

	// Offers one request after a random gap and waits until the block takes it. The task is
	// entered and left at a rising edge, so valid is driven at most once per time step. Ready
	// is sampled at the falling edge, where it is stable for the edge that follows.
	task automatic send_request(cmd_t cmd, logic [TEMP_W-1:0] temp, logic [COUNT_W-1:0] count);
		int unsigned gap;
		logic        taken;
		gap = sender_steady ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			req_ch.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.command     <= cmd;
		req_ch.temp_tenths <= temp;
		req_ch.count_value <= count;
		do begin
			@(negedge clk);
			taken = req_ch.ready;
			@(posedge clk);
		end while (taken !== 1'b1);
		pending_readouts.push_back(format_readout(cmd, temp, count));
	endtask

	// Stops offering requests and waits until every predicted readout has come back.
	task automatic drain();
		req_ch.valid <= 1'b0;
		while (pending_readouts.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// The threshold is only written while the block is empty.
	task automatic write_threshold(logic [THRESH_W-1:0] value);
		drain();
		cfg_we    <= 1'b1;
		cfg_wdata <= value;
		@(posedge clk);
		cfg_we    <= 1'b0;
		warm_thresh = value;
	endtask

	// Right after reset the kept colour is the default font, which a count reports as is.
	task automatic test_reset_colour();
		send_request(CMD_COUNT, 16'h0000, 20'd0);
		send_request(CMD_COUNT, 16'hFFFF, 20'd7);
	endtask

	// Sign handling, zero, saturation of the shown magnitude and the reset threshold edge.
	task automatic test_temperature_extremes();
		send_request(CMD_TEMP, 16'sd0, '0);
		send_request(CMD_TEMP, 16'sd1, '1);
		send_request(CMD_TEMP, -16'sd1, '0);
		send_request(CMD_TEMP, 16'sd9999, '0);
		send_request(CMD_TEMP, 16'sd10000, '0);
		send_request(CMD_TEMP, -16'sd10000, '0);
		send_request(CMD_TEMP, 16'sd32767, '0);
		send_request(CMD_TEMP, 16'h8000, '0);
		send_request(CMD_TEMP, 16'sd377, '0);
		send_request(CMD_TEMP, 16'sd378, '0);
		// A count after a temperature reports the colour that temperature left.
		send_request(CMD_COUNT, 16'h7FFF, 20'd42);
	endtask

	// Blanking boundaries, the comma, and saturation of large counts.
	task automatic test_count_extremes();
		send_request(CMD_COUNT, '0, 20'd10);
		send_request(CMD_COUNT, '0, 20'd100);
		send_request(CMD_COUNT, '0, 20'd999);
		send_request(CMD_COUNT, '0, 20'd1000);
		send_request(CMD_COUNT, '0, 20'd10000);
		send_request(CMD_COUNT, '0, 20'd100000);
		send_request(CMD_COUNT, '0, 20'd999999);
		send_request(CMD_COUNT, '0, 20'd1000000);
		send_request(CMD_COUNT, '1, 20'hFFFFF);
	endtask

	// Threshold zero makes every positive value red. The all-ones threshold lies above the
	// displayable range and is compared with the full magnitude.
	task automatic test_threshold_extremes();
		write_threshold('0);
		send_request(CMD_TEMP, 16'sd1, '0);
		write_threshold('1);
		send_request(CMD_TEMP, 16'sd16382, '0);
		send_request(CMD_TEMP, 16'sd16383, '0);
		write_threshold(THRESH_RESET);
	endtask

	// One random request. Most temperatures sit near zero, near the threshold or near
	// saturation; counts are spread over all digit widths and their blanking edges.
	// The field that the command ignores is always random.
	task automatic send_random_request();
		int unsigned        pick;
		int unsigned        span;
		cmd_t               cmd;
		logic [TEMP_W-1:0]  temp;
		logic [COUNT_W-1:0] count;
		pick  = $urandom_range(0, 9);
		temp  = TEMP_W'($urandom);
		count = COUNT_W'($urandom);
		cmd   = (pick <= 4) ? CMD_TEMP : CMD_COUNT;
		span  = 1;
		case (pick)
			0, 1: begin
				temp = TEMP_W'($urandom_range(0, 2000) - 1000);
			end
			2: begin
				temp = TEMP_W'(warm_thresh + $urandom_range(0, 4) - 2);
			end
			3: begin
				temp = TEMP_W'($urandom);
			end
			4: begin
				temp = TEMP_W'(9998 + $urandom_range(0, 3));
				if ($urandom_range(0, 1) == 1) temp = -temp;
			end
			5, 6: begin
				repeat ($urandom_range(1, 6)) span *= 10;
				count = COUNT_W'($urandom_range(0, span - 1));
			end
			7: begin
				count = COUNT_W'($urandom);
			end
			8: begin
				count = COUNT_W'($urandom_range(999990, 1000010));
			end
			default: begin
				repeat ($urandom_range(1, 6)) span *= 10;
				count = COUNT_W'(span + $urandom_range(0, 2) - 1);
			end
		endcase
		send_request(cmd, temp, count);
	endtask

	// Random traffic in phases, each with its own threshold. The second phase runs with neither
	// side idling; the other phases pace both sides at random.
	task automatic test_random_traffic(int unsigned total);
		logic [THRESH_W-1:0] thresholds[5];
		thresholds = '{THRESH_W'($urandom_range(1, 9998)), THRESH_W'(9999), THRESH_W'(1),
			THRESH_W'($urandom), THRESH_W'($urandom_range(200, 600))};
		for (int phase = 0; phase < 5; phase++) begin
			write_threshold(thresholds[phase]);
			sender_steady   = (phase == 1);
			receiver_steady = (phase == 1);
			repeat (total / 5) send_random_request();
		end
		sender_steady   = 1'b0;
		receiver_steady = 1'b0;
	endtask

	// The receiver holds off for a long stretch while requests keep coming back to back,
	// so the block fills up and has to drop ready on its input.
	task automatic test_output_backpressure();
		drain();
		hold_off_cycles = 200;
		sender_steady   = 1'b1;
		repeat (24) send_random_request();
		sender_steady   = 1'b0;
	endtask

	// Results are taken after a stall (random, none in steady mode, or the hold-off) and compared
	// field by field with the oldest prediction. Valid and the payload are sampled at the falling edge.
	initial begin : result_checker
		int unsigned stall;
		logic        got;
		readout_t    seen;
		readout_t    want;
		res_ch.ready = 1'b0;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_off_cycles > 0) begin
				stall = hold_off_cycles;
				hold_off_cycles = 0;
			end else begin
				stall = receiver_steady ? 0 : $urandom_range(0, 10);
			end
			if (stall > 0) begin
				res_ch.ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			res_ch.ready <= 1'b1;
			do begin
				@(negedge clk);
				got          = res_ch.valid;
				seen.text[0] = res_ch.char0;
				seen.text[1] = res_ch.char1;
				seen.text[2] = res_ch.char2;
				seen.text[3] = res_ch.char3;
				seen.text[4] = res_ch.char4;
				seen.text[5] = res_ch.char5;
				seen.text[6] = res_ch.char6;
				seen.text[7] = res_ch.char7;
				seen.colour  = colour_t'(res_ch.colour_class);
				@(posedge clk);
			end while (got !== 1'b1);
			if (pending_readouts.size() == 0) begin
				$error("readout %h arrived with no request outstanding", seen);
				mismatch_count++;
			end else begin
				want = pending_readouts.pop_front();
				for (int i = 0; i < 8; i++) begin
					if (seen.text[i] !== want.text[i]) begin
						$error("char%0d: expected %h, actual %h", i, want.text[i], seen.text[i]);
						mismatch_count++;
					end
				end
				if (seen.colour !== want.colour) begin
					$error("colour_class: expected %0d, actual %0d", want.colour, seen.colour);
					mismatch_count++;
				end
			end
		end
	end

	initial begin
		arst_n             = 1'b0;
		cfg_we             = 1'b0;
		cfg_wdata          = '0;
		req_ch.valid       = 1'b0;
		req_ch.command     = CMD_TEMP;
		req_ch.temp_tenths = '0;
		req_ch.count_value = '0;
		warm_thresh        = THRESH_RESET;
		kept_colour        = COL_DEFAULT;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(posedge clk);

		test_reset_colour();
		test_temperature_extremes();
		test_count_extremes();
		test_threshold_extremes();
		test_random_traffic(550);
		test_output_backpressure();
		drain();

		if (mismatch_count == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

[decimal_readout_formatter.f]
hw/rtl/drf_pkg.sv
hw/rtl/drf_in_if.sv
hw/rtl/drf_out_if.sv
hw/rtl/drf_front.sv
hw/rtl/drf_queue.sv
hw/rtl/drf_back.sv
hw/rtl/decimal_readout_formatter.sv
tb/sv/tb.sv
